FILE: rtl/ilc_pkg.sv
// Shared types, phase and lamp codes, register indexes and reset values
// for the intersection light controller. No dependencies.
package ilc_pkg;

  localparam int TimeW = 32;
  localparam int CfgW  = 16;
  localparam int AddrW = 3;

  // Road phase codes
  localparam logic [2:0] RD_VERT_GREEN      = 3'd0;
  localparam logic [2:0] RD_VERT_AMBER_OUT  = 3'd1;
  localparam logic [2:0] RD_HORIZ_GREEN     = 3'd2;
  localparam logic [2:0] RD_HORIZ_AMBER_IN  = 3'd3;
  localparam logic [2:0] RD_VERT_AMBER_IN   = 3'd4;
  localparam logic [2:0] RD_HORIZ_AMBER_OUT = 3'd5;

  // Pedestrian phase codes
  localparam logic [1:0] PED_IDLE    = 2'd0;
  localparam logic [1:0] PED_WAITING = 2'd1;
  localparam logic [1:0] PED_WALKING = 2'd2;

  // Lamp colors
  localparam logic [1:0] LAMP_RED   = 2'd0;
  localparam logic [1:0] LAMP_AMBER = 2'd1;
  localparam logic [1:0] LAMP_GREEN = 2'd2;

  // Register indexes
  localparam logic [AddrW-1:0] REG_BLINK_PERIOD = 3'd0;
  localparam logic [AddrW-1:0] REG_PED_WAIT     = 3'd1;
  localparam logic [AddrW-1:0] REG_WALK         = 3'd2;
  localparam logic [AddrW-1:0] REG_AMBER        = 3'd3;
  localparam logic [AddrW-1:0] REG_MIN_GREEN    = 3'd4;
  localparam logic [AddrW-1:0] REG_MAX_RED_WAIT = 3'd5;

  // Register reset values
  localparam logic [CfgW-1:0] BLINK_PERIOD_RST = 16'd300;
  localparam logic [CfgW-1:0] PED_WAIT_RST     = 16'd4000;
  localparam logic [CfgW-1:0] WALK_RST         = 16'd5000;
  localparam logic [CfgW-1:0] AMBER_RST        = 16'd2000;
  localparam logic [CfgW-1:0] MIN_GREEN_RST    = 16'd5000;
  localparam logic [CfgW-1:0] MAX_RED_WAIT_RST = 16'd6000;

  // Result of one road step
  typedef struct packed {
    logic [1:0] vert_color;
    logic [1:0] horiz_color;
    logic [2:0] phase;
  } road_out_t;

  // Result of one pedestrian step
  typedef struct packed {
    logic       ped_red;
    logic       ped_green;
    logic       ped_indicator;
    logic [1:0] phase;
  } ped_out_t;

  // Wrapping elapsed-time check: (now - stamp) mod 2^32 >= limit
  function automatic logic elapsed(input logic [TimeW-1:0] now,
                                   input logic [TimeW-1:0] stamp,
                                   input logic [CfgW-1:0]  limit);
    logic [TimeW-1:0] diff;
    diff = now - stamp;
    return diff >= {{(TimeW-CfgW){1'b0}}, limit};
  endfunction

endpackage

FILE: rtl/ilc_road_fsm.sv
// Six-phase road state machine with its phase and red-wait timers.
// Depends on ilc_pkg.
module ilc_road_fsm (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [ilc_pkg::TimeW-1:0] now_ms,
  input  logic                      vert_car,
  input  logic                      horiz_car,
  input  logic                      ped_request,
  input  logic [ilc_pkg::CfgW-1:0]  amber_ms,
  input  logic [ilc_pkg::CfgW-1:0]  min_green_ms,
  input  logic [ilc_pkg::CfgW-1:0]  max_red_wait_ms,
  output ilc_pkg::road_out_t        road_out
);
  import ilc_pkg::*;

  logic [2:0]       road_state, road_state_next;
  logic [TimeW-1:0] road_phase_start, road_phase_start_next;
  logic [TimeW-1:0] red_wait_start, red_wait_start_next;
  logic [TimeW-1:0] wait_stamp;
  logic             amber_done;

  // Wait stamp as seen this poll: zero means not waiting, so start it now
  assign wait_stamp = (red_wait_start == '0) ? now_ms : red_wait_start;
  assign amber_done = elapsed(now_ms, road_phase_start, amber_ms);

  // Step the road phase
  always_comb begin
    road_state_next       = road_state;
    road_phase_start_next = road_phase_start;
    red_wait_start_next   = red_wait_start;
    road_out.vert_color   = LAMP_RED;
    road_out.horiz_color  = LAMP_RED;
    unique case (road_state)
      RD_VERT_GREEN: begin
        road_out.vert_color = LAMP_GREEN;
        if (horiz_car || ped_request) begin
          red_wait_start_next = wait_stamp;
          if (!vert_car || elapsed(now_ms, wait_stamp, max_red_wait_ms)) begin
            red_wait_start_next   = '0;
            road_state_next       = RD_VERT_AMBER_OUT;
            road_phase_start_next = now_ms;
          end
        end else begin
          red_wait_start_next = '0;
          if (!vert_car && elapsed(now_ms, road_phase_start, min_green_ms)) begin
            road_state_next       = RD_VERT_AMBER_OUT;
            road_phase_start_next = now_ms;
          end
        end
      end
      RD_VERT_AMBER_OUT: begin
        road_out.vert_color = LAMP_AMBER;
        if (amber_done) begin
          road_state_next       = RD_HORIZ_AMBER_IN;
          road_phase_start_next = now_ms;
        end
      end
      RD_HORIZ_AMBER_IN: begin
        road_out.horiz_color = LAMP_AMBER;
        if (amber_done) begin
          road_state_next       = RD_HORIZ_GREEN;
          road_phase_start_next = now_ms;
        end
      end
      RD_HORIZ_GREEN: begin
        road_out.horiz_color = LAMP_GREEN;
        if (vert_car) begin
          red_wait_start_next = wait_stamp;
          if (!horiz_car || elapsed(now_ms, wait_stamp, max_red_wait_ms)) begin
            red_wait_start_next   = '0;
            road_state_next       = RD_HORIZ_AMBER_OUT;
            road_phase_start_next = now_ms;
          end
        end else begin
          red_wait_start_next = '0;
          if ((!horiz_car && elapsed(now_ms, road_phase_start, min_green_ms)) ||
              ped_request) begin
            road_state_next       = RD_HORIZ_AMBER_OUT;
            road_phase_start_next = now_ms;
          end
        end
      end
      RD_HORIZ_AMBER_OUT: begin
        road_out.horiz_color = LAMP_AMBER;
        if (amber_done) begin
          road_state_next       = RD_VERT_AMBER_IN;
          road_phase_start_next = now_ms;
        end
      end
      default: begin
        // vertical amber toward green
        road_out.vert_color = LAMP_AMBER;
        if (amber_done) begin
          road_state_next       = RD_VERT_GREEN;
          road_phase_start_next = now_ms;
        end
      end
    endcase
    road_out.phase = road_state_next;
  end

  // Commit the step when the beat advances
  always_ff @(posedge clk) begin
    if (rst) begin
      road_state       <= RD_VERT_GREEN;
      road_phase_start <= '0;
      red_wait_start   <= '0;
    end else if (step) begin
      road_state       <= road_state_next;
      road_phase_start <= road_phase_start_next;
      red_wait_start   <= red_wait_start_next;
    end
  end

endmodule

FILE: rtl/ilc_ped_fsm.sv
// Three-phase pedestrian state machine with the blinking wait indicator.
// Depends on ilc_pkg.
module ilc_ped_fsm (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [ilc_pkg::TimeW-1:0] now_ms,
  input  logic                      ped_button,
  input  logic [2:0]                road_phase,
  input  logic [ilc_pkg::CfgW-1:0]  blink_period_ms,
  input  logic [ilc_pkg::CfgW-1:0]  ped_wait_ms,
  input  logic [ilc_pkg::CfgW-1:0]  walk_ms,
  output logic                      ped_request,
  output ilc_pkg::ped_out_t         ped_out
);
  import ilc_pkg::*;

  logic [1:0]       ped_state, ped_state_next;
  logic [TimeW-1:0] ped_phase_start, ped_phase_start_next;
  logic [TimeW-1:0] blink_stamp, blink_stamp_next;
  logic             indicator_on, indicator_on_next;
  logic             blink_due;
  logic             stopped;

  assign ped_request = (ped_state == PED_WAITING);
  assign blink_due   = elapsed(now_ms, blink_stamp, blink_period_ms);
  // Cross only while horizontal traffic has right of way (vertical stopped)
  assign stopped     = (road_phase == RD_HORIZ_GREEN) || (road_phase == RD_HORIZ_AMBER_IN);

  // Step the pedestrian phase
  always_comb begin
    ped_state_next        = ped_state;
    ped_phase_start_next  = ped_phase_start;
    blink_stamp_next      = blink_stamp;
    indicator_on_next     = indicator_on;
    ped_out.ped_red       = 1'b0;
    ped_out.ped_green     = 1'b0;
    ped_out.ped_indicator = 1'b0;
    unique case (ped_state)
      PED_IDLE: begin
        ped_out.ped_red = 1'b1;
        if (ped_button) begin
          ped_phase_start_next = now_ms;
          blink_stamp_next     = now_ms;
          indicator_on_next    = 1'b0;
          ped_state_next       = PED_WAITING;
        end
      end
      PED_WAITING: begin
        if (blink_due) begin
          indicator_on_next = ~indicator_on;
          blink_stamp_next  = now_ms;
        end
        ped_out.ped_red       = 1'b1;
        ped_out.ped_indicator = indicator_on_next;
        if (elapsed(now_ms, ped_phase_start, ped_wait_ms) && stopped) begin
          ped_phase_start_next = now_ms;
          ped_state_next       = PED_WALKING;
        end
      end
      default: begin
        // walking
        ped_out.ped_green = 1'b1;
        if (elapsed(now_ms, ped_phase_start, walk_ms)) begin
          ped_state_next = PED_IDLE;
        end
      end
    endcase
    ped_out.phase = ped_state_next;
  end

  // Commit the step when the beat advances
  always_ff @(posedge clk) begin
    if (rst) begin
      ped_state       <= PED_IDLE;
      ped_phase_start <= '0;
      blink_stamp     <= '0;
      indicator_on    <= 1'b0;
    end else if (step) begin
      ped_state       <= ped_state_next;
      ped_phase_start <= ped_phase_start_next;
      blink_stamp     <= blink_stamp_next;
      indicator_on    <= indicator_on_next;
    end
  end

endmodule

FILE: rtl/intersection_light_controller.sv
// Intersection light controller with pedestrian crossing, one poll per beat.
// A result beat passes through the input register, then the result register;
// throughput is one beat per cycle while m_tready does not stall the output.
// The road step feeds the pedestrian step in the same cycle, between the
// two registers. Synchronous active-high reset puts both machines in their
// start phases, clears all timestamps and loads the register defaults.
module intersection_light_controller (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // [31:0] now_ms, [32] ped_button, [33] vert_car, [34] horiz_car, [39:35] zero
  input  logic [39:0]               s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // [0] ped_red, [1] ped_green, [2] ped_indicator, [4:3] vert_color,
  // [6:5] horiz_color, [8:7] ped_phase, [11:9] road_phase, [15:12] zero
  output logic [15:0]               m_tdata,
  input  logic                      cfg_wr_en,
  input  logic [ilc_pkg::AddrW-1:0] cfg_addr,
  input  logic [ilc_pkg::CfgW-1:0]  cfg_wdata
);
  import ilc_pkg::*;

  logic [CfgW-1:0]  blink_period_ms, ped_wait_ms, walk_ms;
  logic [CfgW-1:0]  amber_ms, min_green_ms, max_red_wait_ms;
  logic             in_valid;
  logic [TimeW-1:0] in_now;
  logic             in_button, in_vcar, in_hcar;
  logic             advance;
  logic             ped_request;
  road_out_t        road_out;
  ped_out_t         ped_out;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period_ms <= BLINK_PERIOD_RST;
      ped_wait_ms     <= PED_WAIT_RST;
      walk_ms         <= WALK_RST;
      amber_ms        <= AMBER_RST;
      min_green_ms    <= MIN_GREEN_RST;
      max_red_wait_ms <= MAX_RED_WAIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_BLINK_PERIOD: blink_period_ms <= cfg_wdata;
        REG_PED_WAIT:     ped_wait_ms     <= cfg_wdata;
        REG_WALK:         walk_ms         <= cfg_wdata;
        REG_AMBER:        amber_ms        <= cfg_wdata;
        REG_MIN_GREEN:    min_green_ms    <= cfg_wdata;
        REG_MAX_RED_WAIT: max_red_wait_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Step the held beat when the result register can take it
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_now    <= s_tdata[31:0];
      in_button <= s_tdata[32];
      in_vcar   <= s_tdata[33];
      in_hcar   <= s_tdata[34];
    end
  end

  ilc_road_fsm u_road (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .now_ms          (in_now),
    .vert_car        (in_vcar),
    .horiz_car       (in_hcar),
    .ped_request     (ped_request),
    .amber_ms        (amber_ms),
    .min_green_ms    (min_green_ms),
    .max_red_wait_ms (max_red_wait_ms),
    .road_out        (road_out)
  );

  ilc_ped_fsm u_ped (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .now_ms          (in_now),
    .ped_button      (in_button),
    .road_phase      (road_out.phase),
    .blink_period_ms (blink_period_ms),
    .ped_wait_ms     (ped_wait_ms),
    .walk_ms         (walk_ms),
    .ped_request     (ped_request),
    .ped_out         (ped_out)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {4'b0000, road_out.phase, ped_out.phase, road_out.horiz_color,
                  road_out.vert_color, ped_out.ped_indicator, ped_out.ped_green,
                  ped_out.ped_red};
    end
  end

endmodule
